/* sv/pwed_pkg.sv */
// Package for the windowed energy detector: field widths, register codes
// and reset values. No dependencies; compiled first.
`default_nettype none

package pwed_pkg;

	// Fixed field widths
	localparam int SUM_W      = 37;
	localparam int CNT_W      = 14;
	localparam int MARGIN_W   = 24;
	localparam int HOLD_W     = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_DETECT_MARGIN = 2'd1,
		REG_HOLD_LENGTH   = 2'd2
	} cfg_reg_t;

	// Register reset values
	localparam logic [CNT_W-1:0]    WINDOW_LENGTH_RST = CNT_W'(8192);
	localparam logic [MARGIN_W-1:0] DETECT_MARGIN_RST = MARGIN_W'(2);
	localparam logic [HOLD_W-1:0]   HOLD_LENGTH_RST   = HOLD_W'(2048);

	// Floor starts at the largest sum
	localparam logic [SUM_W-1:0] SUM_ALL_ONES = {SUM_W{1'b1}};

endpackage

`default_nettype wire

/* sv/pwed_ifs.sv */
// Valid/ready channel interfaces for the sample and result words.
// Depends on pwed_pkg for the sum width.
`default_nettype none

interface pwed_sample_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] raw_sample;

	modport source (output valid, output raw_sample, input ready);
	modport sink   (input valid, input raw_sample, output ready);
endinterface

interface pwed_result_if;
	import pwed_pkg::*;

	logic             valid;
	logic             ready;
	logic             motion;
	logic             window_done;
	logic [SUM_W-1:0] noise_floor;
	logic [SUM_W-1:0] window_sum;

	modport source (output valid, output motion, output window_done,
		output noise_floor, output window_sum, input ready);
	modport sink   (input valid, input motion, input window_done,
		input noise_floor, input window_sum, output ready);
endinterface

`default_nettype wire

/* sv/pir_window_energy_detector_unit.sv */
// Windowed energy detector with minimum-tracking noise floor and motion hold.
// Depends on pwed_pkg and the channel interfaces in pwed_ifs.sv.
//
// Usage:
//   sample_in  carries one converter sample word (two's complement code).
//   result_out carries one result word per sample: motion, window_done and,
//   on a window close, the noise floor and the window sum (zero otherwise).
//   cfg_we/cfg_index/cfg_data write window_length (0), detect_margin (1) and
//   hold_length (2); write only while no sample is in flight.
// Timing:
//   A sample is registered in sample_s1 at accept and processed from there;
//   its result word is registered in the s2 registers, turns valid when they
//   load and can then be taken. One sample per cycle is sustained while result_out is ready.
// Stalls:
//   When result_out is not ready the result register holds its word and the
//   input register holds one more sample; sample_in.ready drops only when
//   both are full.
// Reset:
//   arst_n clears the window count, sum, hold counter and motion flag, sets
//   the floor to all ones and loads the register defaults (8192, 2, 2048).
`default_nettype none

module pir_window_energy_detector_unit #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire                           clk,
	input  wire                           arst_n,
	pwed_sample_if.sink                   sample_in,
	pwed_result_if.source                 result_out,
	input  wire                           cfg_we,
	input  wire [pwed_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [pwed_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pwed_pkg::*;

	// Configuration registers
	logic [CNT_W-1:0]    window_length_q;
	logic [MARGIN_W-1:0] detect_margin_q;
	logic [HOLD_W-1:0]   hold_length_q;

	// Detector state
	logic [CNT_W-1:0]  sample_count_q;
	logic [SUM_W-1:0]  energy_sum_q;
	logic [SUM_W-1:0]  floor_min_q;
	logic [HOLD_W-1:0] hold_count_q;
	logic              motion_flag_q;

	// Pipeline registers
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   valid_s2;
	logic                   motion_s2;
	logic                   done_s2;
	logic [SUM_W-1:0]       floor_s2;
	logic [SUM_W-1:0]       sum_s2;

	// Combinational update
	logic                   advance;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SUM_W:0]         sum_wide;
	logic [SUM_W-1:0]       sum_sat;
	logic [CNT_W-1:0]       count_inc;
	logic                   done;
	logic [SUM_W-1:0]       floor_new;
	logic [SUM_W-1:0]       excess;
	logic                   trigger;
	logic [HOLD_W-1:0]      hold_pre;
	logic                   motion_pre;
	logic [HOLD_W-1:0]      hold_next;
	logic                   motion_next;

	// Handshake: result register frees when empty or taken
	assign advance         = !valid_s2 || result_out.ready;
	assign sample_in.ready = !valid_s1 || advance;

	// Magnitude of the sample, most negative code gives 2^(SAMPLE_BITS-1)
	assign mag = sample_s1[SAMPLE_BITS-1] ? (~sample_s1 + 1'b1) : sample_s1;

	// Window sum (saturating) and sample count
	assign sum_wide  = {1'b0, energy_sum_q} + (SUM_W+1)'(mag);
	assign sum_sat   = sum_wide[SUM_W] ? SUM_ALL_ONES : sum_wide[SUM_W-1:0];
	assign count_inc = sample_count_q + 1'b1;
	assign done      = (count_inc >= window_length_q);

	// Floor tracking and trigger on window close
	assign floor_new = (done && (sum_sat < floor_min_q)) ? sum_sat : floor_min_q;
	assign excess    = sum_sat - floor_new;
	assign trigger   = done && (excess > SUM_W'(detect_margin_q));

	// Hold counter: restart on trigger, release at hold_length
	always_comb begin
		hold_pre    = trigger ? HOLD_W'(1) : hold_count_q;
		motion_pre  = trigger ? 1'b1 : motion_flag_q;
		hold_next   = hold_pre;
		motion_next = motion_pre;
		if (hold_pre != '0) begin
			if (hold_pre >= hold_length_q) begin
				hold_next   = '0;
				motion_next = 1'b0;
			end else begin
				hold_next = hold_pre + 1'b1;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
			detect_margin_q <= DETECT_MARGIN_RST;
			hold_length_q   <= HOLD_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[CNT_W-1:0];
				REG_DETECT_MARGIN: detect_margin_q <= cfg_data[MARGIN_W-1:0];
				REG_HOLD_LENGTH:   hold_length_q   <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			sample_count_q <= '0;
			energy_sum_q   <= '0;
			floor_min_q    <= SUM_ALL_ONES;
			hold_count_q   <= '0;
			motion_flag_q  <= 1'b0;
		end else begin
			if (sample_in.ready) begin
				valid_s1 <= sample_in.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					sample_count_q <= done ? '0 : count_inc;
					energy_sum_q   <= done ? '0 : sum_sat;
					floor_min_q    <= floor_new;
					hold_count_q   <= hold_next;
					motion_flag_q  <= motion_next;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (sample_in.ready && sample_in.valid) begin
			sample_s1 <= sample_in.raw_sample;
		end
		if (advance && valid_s1) begin
			motion_s2 <= motion_next;
			done_s2   <= done;
			floor_s2  <= done ? floor_new : '0;
			sum_s2    <= done ? sum_sat : '0;
		end
	end

	assign result_out.valid       = valid_s2;
	assign result_out.motion      = motion_s2;
	assign result_out.window_done = done_s2;
	assign result_out.noise_floor = floor_s2;
	assign result_out.window_sum  = sum_s2;

`ifndef ASSERT_OFF
	// Reported floor never exceeds the reported sum
	a_floor_le_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.window_done |->
			result_out.window_sum >= result_out.noise_floor)
		else $error("noise floor above window sum");

	// Floor and sum read zero outside a window close
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.window_done |->
			result_out.noise_floor == '0 && result_out.window_sum == '0)
		else $error("floor or sum nonzero without window close");

	// Noise floor only falls
	a_floor_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> floor_min_q <= $past(floor_min_q))
		else $error("noise floor increased");

	// Motion is active exactly while the hold counter runs
	a_motion_hold: assert property (@(posedge clk) disable iff (!arst_n)
		motion_flag_q == (hold_count_q != '0))
		else $error("motion flag and hold counter disagree");
`endif

endmodule

`default_nettype wire
